/* hdl/pdcc_pkg.sv */
package pdcc_pkg;

  localparam logic [7:0] SYNC_BYTE    = 8'h55;
  localparam logic [7:0] VERSION_BYTE = 8'h04;
  localparam logic [7:0] CRC8_INIT    = 8'h77;
  localparam logic [7:0] CRC8_POLY    = 8'h8C;
  localparam logic [15:0] CRC16_INIT  = 16'h3692;
  localparam logic [15:0] CRC16_POLY  = 16'h8408;
  localparam logic [8:0] MIN_FRAME    = 9'd13;
  localparam logic [8:0] COUNT_MAX    = 9'd256;

  localparam logic [8:0] POS_LENGTH   = 9'd1;
  localparam logic [8:0] POS_VERSION  = 9'd2;
  localparam logic [8:0] POS_HDR_CRC  = 9'd3;
  localparam logic [8:0] POS_FIELDS   = 9'd4;
  localparam logic [8:0] POS_FIELDS_END = 9'd10;

  typedef enum logic [2:0] {
    ERR_OK       = 3'd0,
    ERR_SHORT    = 3'd1,
    ERR_SYNC     = 3'd2,
    ERR_LENGTH   = 3'd3,
    ERR_VERSION  = 3'd4,
    ERR_HDR_CRC  = 3'd5,
    ERR_BODY_CRC = 3'd6
  } err_t;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic        frame_ok;
    logic [2:0]  error_code;
    logic [15:0] target;
    logic [15:0] sequence_id;
    logic [7:0]  frame_flags;
    logic [7:0]  command_set;
    logic [7:0]  command_id;
    logic [7:0]  payload_length;
    logic        run_end;
  } res_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC8_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC16_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

/* hdl/packet_deframer_crc_check.sv */
// packet deframer with header and body crc checks
//
// input channel: one frame byte per item (data_byte), last_byte set on the
// final byte. output channel: result items, kind 0 for a released payload
// byte, kind 1 for the frame summary (status, error code, header fields).
// payload bytes leave a two-byte delay line, so a byte is reported when the
// byte two places later arrives; its goodness is known only from frame_ok.
// throughput: one byte per cycle while the receiver takes results; the final
// byte of a frame of 14 bytes or more yields two results, which holds in_ready
// low while both wait in the queue. all checks are done in the same cycle an
// item is accepted, between the input handshake and a two-entry result queue.
// the queue lets a new item in while a result still waits, if that result is
// taken in that cycle; when the receiver stalls, results stay in the queue
// unchanged and in_ready drops once the queue cannot take what the next item
// may yield. reset clears the queue, holds in_ready low and returns the parser
// to the start of a frame.
module packet_deframer_crc_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [7:0]  payload_byte,
  output logic        frame_ok,
  output logic [2:0]  error_code,
  output logic [15:0] target,
  output logic [15:0] sequence_id,
  output logic [7:0]  frame_flags,
  output logic [7:0]  command_set,
  output logic [7:0]  command_id,
  output logic [7:0]  payload_length,
  output logic        run_end
);

  logic [8:0]  byte_count;
  logic [7:0]  header_crc;
  logic [15:0] body_crc;
  logic [7:0]  delay0, delay1;
  logic [7:0]  length_byte;
  logic [55:0] header_fields;
  logic [2:0]  early_error;

  logic [2:0]  early_error_next;
  logic [7:0]  length_byte_next;
  logic [55:0] header_fields_next;
  logic [7:0]  header_crc_next;
  logic [15:0] body_crc_next;
  logic [8:0]  frame_len;
  logic [15:0] stored_crc;
  logic [2:0]  err;
  logic        accept, pop, has_payload;

  pdcc_pkg::res_t q0, q1, q0_next, q1_next, res_pay, res_sum, first_new, second_new, rem0;
  logic [1:0] qcnt, qcnt_next, remcnt, npush;

  assign accept    = in_valid && in_ready;
  assign out_valid = (qcnt != 2'd0);
  assign pop       = out_valid && out_ready;
  assign in_ready  = !rst && ((qcnt == 2'd0) || ((qcnt == 2'd1) && out_ready));

  always_comb begin
    early_error_next   = early_error;
    length_byte_next   = length_byte;
    header_fields_next = header_fields;
    unique case (byte_count)
      9'd0: begin
        if (data_byte != pdcc_pkg::SYNC_BYTE) early_error_next = pdcc_pkg::ERR_SYNC;
      end
      pdcc_pkg::POS_LENGTH: length_byte_next = data_byte;
      pdcc_pkg::POS_VERSION: begin
        if (data_byte != pdcc_pkg::VERSION_BYTE && early_error == pdcc_pkg::ERR_OK)
          early_error_next = pdcc_pkg::ERR_VERSION;
      end
      pdcc_pkg::POS_HDR_CRC: begin
        if (header_crc != data_byte && early_error == pdcc_pkg::ERR_OK)
          early_error_next = pdcc_pkg::ERR_HDR_CRC;
      end
      default: begin
        if (byte_count >= pdcc_pkg::POS_FIELDS && byte_count <= pdcc_pkg::POS_FIELDS_END)
          header_fields_next[{3'(byte_count[2:0] - 3'd4), 3'b000} +: 8] = data_byte;
      end
    endcase
  end

  assign header_crc_next = (byte_count < 9'd3) ? pdcc_pkg::crc8_step(header_crc, data_byte)
                                               : header_crc;
  assign body_crc_next   = (byte_count >= 9'd2) ? pdcc_pkg::crc16_step(body_crc, delay1)
                                                : body_crc;
  assign has_payload = (byte_count >= pdcc_pkg::MIN_FRAME);
  assign frame_len   = (byte_count < pdcc_pkg::COUNT_MAX) ? byte_count + 9'd1
                                                          : pdcc_pkg::COUNT_MAX;
  assign stored_crc  = {data_byte, delay0};

  always_comb begin
    if (frame_len < pdcc_pkg::MIN_FRAME)             err = pdcc_pkg::ERR_SHORT;
    else if (early_error_next == pdcc_pkg::ERR_SYNC) err = pdcc_pkg::ERR_SYNC;
    else if ({1'b0, length_byte_next} != frame_len)  err = pdcc_pkg::ERR_LENGTH;
    else if (early_error_next != pdcc_pkg::ERR_OK)   err = early_error_next;
    else if (body_crc_next != stored_crc)            err = pdcc_pkg::ERR_BODY_CRC;
    else                                             err = pdcc_pkg::ERR_OK;
  end

  always_comb begin
    res_pay              = '0;
    res_pay.kind         = pdcc_pkg::KIND_PAYLOAD;
    res_pay.payload_byte = delay1;
    res_pay.run_end      = !last_byte;

    res_sum            = '0;
    res_sum.kind       = pdcc_pkg::KIND_SUMMARY;
    res_sum.error_code = err;
    res_sum.run_end    = 1'b1;
    if (err == pdcc_pkg::ERR_OK) begin
      res_sum.frame_ok       = 1'b1;
      res_sum.target         = header_fields_next[15:0];
      res_sum.sequence_id    = header_fields_next[31:16];
      res_sum.frame_flags    = header_fields_next[39:32];
      res_sum.command_set    = header_fields_next[47:40];
      res_sum.command_id     = header_fields_next[55:48];
      res_sum.payload_length = 8'(frame_len - pdcc_pkg::MIN_FRAME);
    end
  end

  // result queue: survivors first, then the new results in order
  always_comb begin
    first_new  = has_payload ? res_pay : res_sum;
    second_new = res_sum;
    if (!accept)               npush = 2'd0;
    else if (has_payload && last_byte) npush = 2'd2;
    else if (has_payload || last_byte) npush = 2'd1;
    else                       npush = 2'd0;
    rem0      = pop ? q1 : q0;
    remcnt    = qcnt - {1'b0, pop};
    qcnt_next = remcnt + npush;
    if (remcnt == 2'd2) begin
      q0_next = q0;
      q1_next = q1;
    end else if (remcnt == 2'd1) begin
      q0_next = rem0;
      q1_next = first_new;
    end else begin
      q0_next = first_new;
      q1_next = second_new;
    end
  end

  always_ff @(posedge clk) begin
    q0 <= q0_next;
    q1 <= q1_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qcnt          <= 2'd0;
      byte_count    <= '0;
      header_crc    <= pdcc_pkg::CRC8_INIT;
      body_crc      <= pdcc_pkg::CRC16_INIT;
      delay0        <= '0;
      delay1        <= '0;
      length_byte   <= '0;
      header_fields <= '0;
      early_error   <= pdcc_pkg::ERR_OK;
    end else begin
      qcnt <= qcnt_next;
      if (accept) begin
        if (last_byte) begin
          byte_count    <= '0;
          header_crc    <= pdcc_pkg::CRC8_INIT;
          body_crc      <= pdcc_pkg::CRC16_INIT;
          delay0        <= '0;
          delay1        <= '0;
          length_byte   <= '0;
          header_fields <= '0;
          early_error   <= pdcc_pkg::ERR_OK;
        end else begin
          if (byte_count < pdcc_pkg::COUNT_MAX) byte_count <= byte_count + 9'd1;
          header_crc    <= header_crc_next;
          body_crc      <= body_crc_next;
          delay1        <= delay0;
          delay0        <= data_byte;
          length_byte   <= length_byte_next;
          header_fields <= header_fields_next;
          early_error   <= early_error_next;
        end
      end
    end
  end

  assign kind           = q0.kind;
  assign payload_byte   = q0.payload_byte;
  assign frame_ok       = q0.frame_ok;
  assign error_code     = q0.error_code;
  assign target         = q0.target;
  assign sequence_id    = q0.sequence_id;
  assign frame_flags    = q0.frame_flags;
  assign command_set    = q0.command_set;
  assign command_id     = q0.command_id;
  assign payload_length = q0.payload_length;
  assign run_end        = q0.run_end;

endmodule

/* tb/sv/packet_deframer_crc_check_tb.sv */
module packet_deframer_crc_check_tb;
  timeunit 1ns;
  timeprecision 1ps;

  class deframer_scoreboard;
    localparam int PAYLOAD_START = 11;

    pdcc_pkg::res_t expected_results[$];
    int             errors;
    logic [8:0]     byte_pos;
    logic [7:0]     hdr_crc;
    logic [15:0]    body_crc;
    logic [7:0]     dly0;
    logic [7:0]     dly1;
    logic [7:0]     len_field;
    logic [55:0]    hdr_fields;
    pdcc_pkg::err_t early_err;

    function new();
      errors = 0;
      restart();
    endfunction

    function void restart();
      byte_pos   = '0;
      hdr_crc    = pdcc_pkg::CRC8_INIT;
      body_crc   = pdcc_pkg::CRC16_INIT;
      dly0       = '0;
      dly1       = '0;
      len_field  = '0;
      hdr_fields = '0;
      early_err  = pdcc_pkg::ERR_OK;
    endfunction

    // reflected crc, one data bit at a time, lsb first
    static function logic [7:0] crc8(logic [7:0] c, logic [7:0] d);
      logic fb;
      for (int i = 0; i < 8; i++) begin
        fb = c[0] ^ d[i];
        c  = c >> 1;
        if (fb) c = c ^ pdcc_pkg::CRC8_POLY;
      end
      return c;
    endfunction

    static function logic [15:0] crc16(logic [15:0] c, logic [7:0] d);
      logic fb;
      for (int i = 0; i < 8; i++) begin
        fb = c[0] ^ d[i];
        c  = c >> 1;
        if (fb) c = c ^ pdcc_pkg::CRC16_POLY;
      end
      return c;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      pdcc_pkg::res_t r;
      logic [8:0]     flen;
      logic [15:0]    stored;
      pdcc_pkg::err_t err;
      int             made;
      made = 0;
      case (byte_pos)
        9'd0: if (b != pdcc_pkg::SYNC_BYTE) early_err = pdcc_pkg::ERR_SYNC;
        pdcc_pkg::POS_LENGTH: len_field = b;
        pdcc_pkg::POS_VERSION:
          if (b != pdcc_pkg::VERSION_BYTE && early_err == pdcc_pkg::ERR_OK)
            early_err = pdcc_pkg::ERR_VERSION;
        pdcc_pkg::POS_HDR_CRC:
          if (b != hdr_crc && early_err == pdcc_pkg::ERR_OK)
            early_err = pdcc_pkg::ERR_HDR_CRC;
        default: begin
          if (byte_pos >= pdcc_pkg::POS_FIELDS && byte_pos <= pdcc_pkg::POS_FIELDS_END)
            hdr_fields[(byte_pos - pdcc_pkg::POS_FIELDS) * 8 +: 8] = b;
        end
      endcase
      if (byte_pos < pdcc_pkg::POS_HDR_CRC) hdr_crc = crc8(hdr_crc, b);

      if (byte_pos >= pdcc_pkg::POS_VERSION) begin
        body_crc = crc16(body_crc, dly1);
        if (byte_pos - pdcc_pkg::POS_VERSION >= PAYLOAD_START) begin
          r = '0;
          r.kind = pdcc_pkg::KIND_PAYLOAD;
          r.payload_byte = dly1;
          expected_results.push_back(r);
          made++;
        end
      end

      if (last) begin
        stored = {b, dly0};
        flen = (byte_pos < pdcc_pkg::COUNT_MAX) ? byte_pos + 9'd1 : pdcc_pkg::COUNT_MAX;
        if (flen < pdcc_pkg::MIN_FRAME) err = pdcc_pkg::ERR_SHORT;
        else if (early_err == pdcc_pkg::ERR_SYNC) err = pdcc_pkg::ERR_SYNC;
        else if ({1'b0, len_field} != flen) err = pdcc_pkg::ERR_LENGTH;
        else if (early_err != pdcc_pkg::ERR_OK) err = early_err;
        else if (body_crc != stored) err = pdcc_pkg::ERR_BODY_CRC;
        else err = pdcc_pkg::ERR_OK;
        r = '0;
        r.kind = pdcc_pkg::KIND_SUMMARY;
        r.error_code = err;
        if (err == pdcc_pkg::ERR_OK) begin
          r.frame_ok       = 1'b1;
          r.target         = hdr_fields[15:0];
          r.sequence_id    = hdr_fields[31:16];
          r.frame_flags    = hdr_fields[39:32];
          r.command_set    = hdr_fields[47:40];
          r.command_id     = hdr_fields[55:48];
          r.payload_length = 8'(flen - pdcc_pkg::MIN_FRAME);
        end
        expected_results.push_back(r);
        made++;
        restart();
      end else begin
        dly1 = dly0;
        dly0 = b;
        if (byte_pos < pdcc_pkg::COUNT_MAX) byte_pos = byte_pos + 9'd1;
      end

      if (made > 0) expected_results[expected_results.size() - 1].run_end = 1'b1;
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(pdcc_pkg::res_t got);
      pdcc_pkg::res_t want;
      if (expected_results.size() == 0) begin
        $error("unexpected result item %h", got);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      check_field("kind", 16'(want.kind), 16'(got.kind));
      check_field("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
      check_field("frame_ok", 16'(want.frame_ok), 16'(got.frame_ok));
      check_field("error_code", 16'(want.error_code), 16'(got.error_code));
      check_field("target", want.target, got.target);
      check_field("sequence_id", want.sequence_id, got.sequence_id);
      check_field("frame_flags", 16'(want.frame_flags), 16'(got.frame_flags));
      check_field("command_set", 16'(want.command_set), 16'(got.command_set));
      check_field("command_id", 16'(want.command_id), 16'(got.command_id));
      check_field("payload_length", 16'(want.payload_length), 16'(got.payload_length));
      check_field("run_end", 16'(want.run_end), 16'(got.run_end));
    endfunction
  endclass

  localparam int unsigned FLAW_SYNC     = 1;
  localparam int unsigned FLAW_LENGTH   = 2;
  localparam int unsigned FLAW_VERSION  = 4;
  localparam int unsigned FLAW_HDR_CRC  = 8;
  localparam int unsigned FLAW_BODY_CRC = 16;
  localparam int unsigned FLAW_NOISE    = 32;
  localparam int unsigned FLAW_ALL_HDR  = 31;
  localparam int FILL_RANDOM = -1;
  localparam int ITEM_TARGET = 450;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        kind;
  logic [7:0]  payload_byte;
  logic        frame_ok;
  logic [2:0]  error_code;
  logic [15:0] target;
  logic [15:0] sequence_id;
  logic [7:0]  frame_flags;
  logic [7:0]  command_set;
  logic [7:0]  command_id;
  logic [7:0]  payload_length;
  logic        run_end;

  deframer_scoreboard sb = new();
  logic [7:0] frame_q[$];
  bit quiet = 1'b0;
  int cycles = 0;
  int items_sent = 0;

  always #5 clk = ~clk;

  packet_deframer_crc_check dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .payload_byte(payload_byte),
    .frame_ok(frame_ok),
    .error_code(error_code),
    .target(target),
    .sequence_id(sequence_id),
    .frame_flags(frame_flags),
    .command_set(command_set),
    .command_id(command_id),
    .payload_length(payload_length),
    .run_end(run_end)
  );

  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] flip();
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic void make_frame(int len, int unsigned flaws, int fill);
    logic [7:0]  hc;
    logic [15:0] bc;
    int          k;
    frame_q.delete();
    for (int i = 0; i < len; i++)
      frame_q.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
    if ((flaws & FLAW_NOISE) != 0 || len < 4) return;
    frame_q[0] = pdcc_pkg::SYNC_BYTE ^ (((flaws & FLAW_SYNC) != 0) ? flip() : 8'h00);
    frame_q[1] = 8'(len) ^ (((flaws & FLAW_LENGTH) != 0) ? flip() : 8'h00);
    frame_q[2] = pdcc_pkg::VERSION_BYTE ^ (((flaws & FLAW_VERSION) != 0) ? flip() : 8'h00);
    hc = pdcc_pkg::CRC8_INIT;
    for (int i = 0; i < 3; i++) hc = deframer_scoreboard::crc8(hc, frame_q[i]);
    frame_q[3] = hc ^ (((flaws & FLAW_HDR_CRC) != 0) ? flip() : 8'h00);
    if (len < 6) return;
    bc = pdcc_pkg::CRC16_INIT;
    for (int i = 0; i < len - 2; i++) bc = deframer_scoreboard::crc16(bc, frame_q[i]);
    frame_q[len - 2] = bc[7:0];
    frame_q[len - 1] = bc[15:8];
    if ((flaws & FLAW_BODY_CRC) != 0) begin
      k = $urandom_range(4, len - 1);
      frame_q[k] = frame_q[k] ^ flip();
    end
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    int gap;
    gap = pick_pause();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    last_byte <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte(b, last);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++)
      send_byte(frame_q[i], i == frame_q.size() - 1);
    items_sent += frame_q.size();
  endtask

  // result side: take items with random back-pressure
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready)
        sb.check_result(pdcc_pkg::res_t'({kind, payload_byte, frame_ok, error_code, target,
                                          sequence_id, frame_flags, command_set,
                                          command_id, payload_length, run_end}));
      if (stall == 0 && $urandom_range(0, 2) == 0) stall = pick_pause();
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int frame_no;
    int len;
    int r;
    int unsigned flaws;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // one-byte and two-byte frames, then a minimum good frame with all-ones fields and an eight-byte noise frame
    make_frame(1, FLAW_NOISE, 8'h00);
    send_frame();
    make_frame(2, FLAW_NOISE, 8'h55);
    frame_q[1] = 8'hff;
    send_frame();
    make_frame(13, 0, 8'hff);
    send_frame();
    make_frame(8, FLAW_NOISE, FILL_RANDOM);
    send_frame();

    frame_no = 0;
    while (items_sent < ITEM_TARGET) begin
      quiet = ($urandom_range(0, 7) == 0);
      if (frame_no == 1) begin
        // byte count saturation
        make_frame($urandom_range(257, 260), 0, FILL_RANDOM);
        send_frame();
      end else begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          len = $urandom_range(1, 12);
          flaws = 0;
        end else if (r < 13) begin
          len = $urandom_range(1, 30);
          flaws = FLAW_NOISE;
        end else begin
          len = $urandom_range(13, 40);
          flaws = ($urandom_range(0, 99) < 60) ? 0 : $urandom_range(1, FLAW_ALL_HDR);
        end
        make_frame(len, flaws, FILL_RANDOM);
        send_frame();
      end
      frame_no++;
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
